// ===== hw/rtl/tbt_pkg.sv =====
// Shared types and constants of the timeline branch table.
`timescale 1ns / 1ps

package tbt_pkg;

  localparam int TL_ID_W           = 10;
  localparam int LSN_W             = 64;
  localparam int NUM_TIMELINES_DEF = 1024;

  typedef enum logic {
    CMD_CREATE = 1'b0,
    CMD_STEP   = 1'b1
  } tbt_cmd_t;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic               defined;
    logic [TL_ID_W-1:0] parent;
    logic [LSN_W-1:0]   branch_point;
  } tbt_entry_t;

endpackage

// ===== hw/rtl/tbt_if.sv =====
// Handshake channels for command words and result words.
`timescale 1ns / 1ps

interface tbt_in_if
  import tbt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               command;
  logic [TL_ID_W-1:0] timeline_id;
  logic [TL_ID_W-1:0] parent_id;
  logic [LSN_W-1:0]   lsn;

  modport source (output valid, command, timeline_id, parent_id, lsn, input ready);
  modport sink   (input valid, command, timeline_id, parent_id, lsn, output ready);
endinterface

interface tbt_out_if
  import tbt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               status;
  logic               has_parent;
  logic [TL_ID_W-1:0] parent_out;
  logic [LSN_W-1:0]   capped_lsn;

  modport source (output valid, status, has_parent, parent_out, capped_lsn, input ready);
  modport sink   (input valid, status, has_parent, parent_out, capped_lsn, output ready);
endinterface

// ===== hw/rtl/tbt_mem.sv =====
// Timeline entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tbt_mem
  import tbt_pkg::*;
#(
  parameter int DEPTH = NUM_TIMELINES_DEF,
  parameter int AW    = $clog2(NUM_TIMELINES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tbt_entry_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output tbt_entry_t    rdata
);

  tbt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tbt_ctrl.sv =====
// Sequencer: clearing pass, entry lookup, ancestry walk and result register.
`timescale 1ns / 1ps

module tbt_ctrl
  import tbt_pkg::*;
#(
  parameter int NUM_TIMELINES = NUM_TIMELINES_DEF,
  parameter int AW            = $clog2(NUM_TIMELINES_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  tbt_in_if.sink        in_ch,
  tbt_out_if.source     out_ch,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output tbt_entry_t    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  tbt_entry_t    mem_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_WALK,
    S_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_cnt;
  tbt_cmd_t           cmd;
  logic [TL_ID_W-1:0] id;
  logic [TL_ID_W-1:0] par;
  logic [LSN_W-1:0]   lsn;
  logic [TL_ID_W-1:0] walk_t;
  logic               res_status;
  logic               res_has_parent;
  logic [TL_ID_W-1:0] res_parent;
  logic [LSN_W-1:0]   res_lsn;

  logic in_fire;
  logic id_in_range;
  logic par_in_range;
  logic new_bad;
  logic step_hit;
  logic walk_reject;
  logic walk_accept;
  logic slot_free;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign id_in_range  = int'(id) < NUM_TIMELINES;
  assign par_in_range = int'(par) < NUM_TIMELINES;
  assign new_bad      = (id == '0) || !id_in_range || mem_rdata.defined;
  assign step_hit     = (id != '0) && id_in_range && mem_rdata.defined;
  assign walk_reject  = (walk_t == id) || !mem_rdata.defined;
  assign walk_accept  = !walk_reject && (walk_t == '0);
  assign slot_free    = !out_ch.valid || out_ch.ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(id);
    mem_wdata = '{defined: 1'b1, parent: par, branch_point: lsn};
    mem_re    = 1'b0;
    mem_raddr = AW'(in_ch.timeline_id);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '{defined: (clr_cnt == '0), parent: '0, branch_point: '0};
      end
      S_IDLE: begin
        mem_re = in_fire;
      end
      S_LOOK: begin
        mem_re    = (cmd == CMD_CREATE) && !new_bad && par_in_range;
        mem_raddr = AW'(par);
      end
      S_WALK: begin
        mem_we    = walk_accept;
        mem_re    = !walk_reject && !walk_accept;
        mem_raddr = AW'(mem_rdata.parent);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(NUM_TIMELINES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd   <= tbt_cmd_t'(in_ch.command);
            id    <= in_ch.timeline_id;
            par   <= in_ch.parent_id;
            lsn   <= in_ch.lsn;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_status     <= ST_OK;
          res_has_parent <= 1'b0;
          res_parent     <= '0;
          res_lsn        <= '0;
          if (cmd == CMD_STEP) begin
            state <= S_DONE;
            if (step_hit) begin
              res_has_parent <= 1'b1;
              res_parent     <= mem_rdata.parent;
              res_lsn        <= (mem_rdata.branch_point < lsn) ? mem_rdata.branch_point : lsn;
            end else begin
              res_lsn <= lsn;
            end
          end else if (new_bad || !par_in_range) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else begin
            walk_t <= par;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_reject) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else if (walk_accept) begin
            state <= S_DONE;
          end else begin
            walk_t <= mem_rdata.parent;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_ch.valid      <= 1'b1;
            out_ch.status     <= res_status;
            out_ch.has_parent <= res_has_parent;
            out_ch.parent_out <= res_parent;
            out_ch.capped_lsn <= res_lsn;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/timeline_branch_table_top.sv =====
// Top level of the timeline branch table.
//
//   channel  | dir | word
//   ---------+-----+--------------------------------------------------
//   in_ch    | in  | command, timeline_id, parent_id, lsn
//   out_ch   | out | status, has_parent, parent_out, capped_lsn
//
// An ancestor step passes through the lookup state to the done state, where the
// output register loads. A create branch rejected at lookup takes the same path.
// Any other create branch also walks the entries from the parent up to the root;
// each entry checked costs one read of the entry memory.
// After reset, in_ch.ready stays low while a clearing pass writes every entry.
// One word is processed at a time; a new word is accepted while the previous
// result still waits in the output register, and a stalled output holds the
// sequencer before it loads the next result.
`timescale 1ns / 1ps

module timeline_branch_table_top
  import tbt_pkg::*;
#(
  parameter int NUM_TIMELINES = NUM_TIMELINES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tbt_in_if.sink    in_ch,
  tbt_out_if.source out_ch
);

  localparam int AW = $clog2(NUM_TIMELINES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  tbt_entry_t    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  tbt_entry_t    mem_rdata;

  tbt_ctrl #(
    .NUM_TIMELINES (NUM_TIMELINES),
    .AW            (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tbt_mem #(
    .DEPTH (NUM_TIMELINES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/tbt_checker.sv =====
// Port-level checks of the timeline branch table, bound to the top level.
`timescale 1ns / 1ps

module tbt_checker
  import tbt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               status,
  input logic               has_parent,
  input logic [TL_ID_W-1:0] parent_out,
  input logic [LSN_W-1:0]   capped_lsn
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("Input ready right after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second word accepted while one is in flight.");

  a_reject_no_parent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REJECT |-> !has_parent && parent_out == '0
                                         && capped_lsn == '0)
    else $error("Rejected create carries ancestor data.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(has_parent)
                                && $stable(parent_out) && $stable(capped_lsn))
    else $error("Stalled result word changed.");

endmodule

bind timeline_branch_table_top tbt_checker u_tbt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .has_parent (out_ch.has_parent),
  .parent_out (out_ch.parent_out),
  .capped_lsn (out_ch.capped_lsn)
);

// ===== dv/tbt_lineage_checker.sv =====
// Checker that mirrors the timeline table and compares every result word.
`timescale 1ns / 1ps

module tbt_lineage_checker
  import tbt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tbt_in_if    in_ch,
  tbt_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int NUM_TL = NUM_TIMELINES_DEF;

  typedef struct packed {
    logic               status;
    logic               has_parent;
    logic [TL_ID_W-1:0] parent;
    logic [LSN_W-1:0]   lsn;
  } reply_t;

  logic               tl_defined      [NUM_TL];
  logic               tl_root_child   [NUM_TL];
  logic [TL_ID_W-1:0] tl_parent       [NUM_TL];
  logic [LSN_W-1:0]   tl_branch_point [NUM_TL];

  reply_t expected_replies[$];
  reply_t want;
  int     idx;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic log_error(input string msg);
    if (fail_count < 40) begin
      $display("%0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  // The branch is legal only if the walk from the parent reaches the root
  // through defined entries without passing the new id.
  function automatic logic lineage_ok(input logic [TL_ID_W-1:0] new_id,
                                      input logic [TL_ID_W-1:0] par);
    logic [TL_ID_W-1:0] t;
    int                 steps;
    t = par;
    if (new_id == '0 || tl_defined[new_id] || !tl_defined[par]) return 1'b0;
    for (steps = 0; steps < NUM_TL; steps++) begin
      if (t == new_id || !tl_defined[t]) return 1'b0;
      if (t == '0) return 1'b1;
      t = tl_parent[t];
    end
    return 1'b0;
  endfunction

  task automatic apply_word(input tbt_cmd_t cmd, input logic [TL_ID_W-1:0] id,
                            input logic [TL_ID_W-1:0] par, input logic [LSN_W-1:0] lsn);
    reply_t r;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_CREATE) begin
      if (lineage_ok(id, par)) begin
        tl_defined[id]      = 1'b1;
        tl_parent[id]       = par;
        tl_branch_point[id] = lsn;
        tl_root_child[id]   = (par == '0);
      end else begin
        r.status = ST_REJECT;
      end
    end else if (id != '0 && tl_defined[id]) begin
      r.has_parent = 1'b1;
      r.parent     = tl_parent[id];
      r.lsn        = (tl_branch_point[id] < lsn) ? tl_branch_point[id] : lsn;
    end else begin
      r.lsn = lsn;
    end
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (idx = 0; idx < NUM_TL; idx++) begin
        tl_defined[idx]      = 1'b0;
        tl_root_child[idx]   = 1'b0;
        tl_parent[idx]       = '0;
        tl_branch_point[idx] = '0;
      end
      tl_defined[0] = 1'b1;
      expected_replies.delete();
    end else begin
      // A result leaving now belongs to an earlier word, so it is checked first.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          log_error($sformatf("unexpected result word: status %0b has_parent %0b",
                              out_ch.status, out_ch.has_parent));
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.status !== want.status)
            log_error($sformatf("status: got %0b, want %0b", out_ch.status, want.status));
          if (out_ch.has_parent !== want.has_parent)
            log_error($sformatf("has_parent: got %0b, want %0b",
                                out_ch.has_parent, want.has_parent));
          if (out_ch.parent_out !== want.parent)
            log_error($sformatf("parent_out: got %0d, want %0d",
                                out_ch.parent_out, want.parent));
          if (out_ch.capped_lsn !== want.lsn)
            log_error($sformatf("capped_lsn: got %0h, want %0h",
                                out_ch.capped_lsn, want.lsn));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_word(tbt_cmd_t'(in_ch.command), in_ch.timeline_id, in_ch.parent_id, in_ch.lsn);
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ===== dv/tb_timeline_branch_table_top.sv =====
// Testbench top: drives branch and ancestor-step words and gives the verdict.
`timescale 1ns / 1ps

module tb_timeline_branch_table_top
  import tbt_pkg::*;
();

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int NUM_TL      = NUM_TIMELINES_DEF;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sink_hold;
  int   hold_req;
  int   hold_seen;
  bit   steady;

  logic             tr_def [NUM_TL];
  logic [LSN_W-1:0] tr_lsn [NUM_TL];
  int               created_ids[$];
  int               last_created;

  tbt_in_if  in_ch();
  tbt_out_if out_ch();

  timeline_branch_table_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tbt_lineage_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    sink_hold    = 0;
    hold_seen    = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        sink_hold = HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  task automatic send_word(input tbt_cmd_t cmd, input logic [TL_ID_W-1:0] id,
                           input logic [TL_ID_W-1:0] par, input logic [LSN_W-1:0] lsn);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.timeline_id <= id;
    in_ch.parent_id   <= par;
    in_ch.lsn         <= lsn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Keeps track of which timelines exist so that most branches are well formed.
  task automatic issue(input tbt_cmd_t cmd, input logic [TL_ID_W-1:0] id,
                       input logic [TL_ID_W-1:0] par, input logic [LSN_W-1:0] lsn);
    send_word(cmd, id, par, lsn);
    if (cmd == CMD_CREATE && id != '0 && !tr_def[id] && tr_def[par]) begin
      tr_def[id] = 1'b1;
      tr_lsn[id] = lsn;
      created_ids.push_back(int'(id));
      last_created = int'(id);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [TL_ID_W-1:0] any_defined();
    if (created_ids.size() == 0) return '0;
    return TL_ID_W'(created_ids[$urandom_range(created_ids.size() - 1)]);
  endfunction

  function automatic logic [LSN_W-1:0] any_lsn();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_word();
    int                 r;
    int                 tries;
    logic [TL_ID_W-1:0] id;
    logic [TL_ID_W-1:0] par;
    logic [LSN_W-1:0]   lsn;
    r   = $urandom_range(99);
    lsn = any_lsn();
    if (r < 35) begin
      id    = TL_ID_W'($urandom_range(1, NUM_TL - 1));
      tries = 0;
      while (tr_def[id] && tries < 64) begin
        id = TL_ID_W'($urandom_range(1, NUM_TL - 1));
        tries++;
      end
      if ($urandom_range(9) < 3) par = TL_ID_W'(last_created);
      else if ($urandom_range(3) == 0) par = '0;
      else par = any_defined();
      issue(CMD_CREATE, id, par, lsn);
    end else if (r < 45) begin
      id  = TL_ID_W'($urandom);
      par = TL_ID_W'($urandom);
      case ($urandom_range(3))
        0: begin
          id  = '0;
          par = any_defined();
        end
        1: id = any_defined();
        2: begin
          tries = 0;
          while (tr_def[par] && tries < 64) begin
            par = TL_ID_W'($urandom);
            tries++;
          end
        end
        default: ;
      endcase
      issue(CMD_CREATE, id, par, lsn);
    end else if (r < 90) begin
      id = any_defined();
      case ($urandom_range(3))
        0:       lsn = tr_lsn[id];
        1:       lsn = $urandom_range(1) ? tr_lsn[id] + 64'd1 : tr_lsn[id] - 64'd1;
        default: ;
      endcase
      issue(CMD_STEP, id, TL_ID_W'($urandom), lsn);
    end else begin
      id = ($urandom_range(3) == 0) ? '0 : TL_ID_W'($urandom);
      issue(CMD_STEP, id, TL_ID_W'($urandom), lsn);
    end
  endtask

  initial begin
    rst               = 1'b1;
    steady            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_CREATE;
    in_ch.timeline_id = '0;
    in_ch.parent_id   = '0;
    in_ch.lsn         = '0;
    for (int i = 0; i < NUM_TL; i++) begin
      tr_def[i] = 1'b0;
      tr_lsn[i] = '0;
    end
    tr_def[0]    = 1'b1;
    last_created = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Root, undefined ids, rejected branches, a small tree and capping on both sides.
    issue(CMD_STEP, 10'd0, 10'd0, '0);
    issue(CMD_STEP, 10'd0, 10'd1023, '1);
    issue(CMD_STEP, 10'd1023, 10'd0, 64'h0123_4567_89ab_cdef);
    issue(CMD_CREATE, 10'd0, 10'd0, 64'd5);
    issue(CMD_CREATE, 10'd1, 10'd0, 64'd100);
    issue(CMD_CREATE, 10'd1, 10'd0, 64'd7);
    issue(CMD_CREATE, 10'd2, 10'd1023, 64'd8);
    issue(CMD_CREATE, 10'd3, 10'd3, 64'd9);
    issue(CMD_CREATE, 10'd1023, 10'd1, '1);
    issue(CMD_CREATE, 10'd512, 10'd1023, '0);
    issue(CMD_CREATE, 10'd0, 10'd1023, 64'd1);
    issue(CMD_CREATE, 10'd1023, 10'd512, 64'd3);
    issue(CMD_CREATE, 10'd341, 10'd512, 64'haaaa_aaaa_aaaa_aaaa);
    issue(CMD_CREATE, 10'd682, 10'd341, 64'h5555_5555_5555_5555);
    issue(CMD_STEP, 10'd512, 10'd0, '1);
    issue(CMD_STEP, 10'd1023, 10'd0, 64'd5);
    issue(CMD_STEP, 10'd1, 10'd0, 64'd100);
    issue(CMD_STEP, 10'd1, 10'd0, 64'd99);
    issue(CMD_STEP, 10'd1, 10'd0, 64'd101);
    issue(CMD_STEP, 10'd682, 10'd1023, '0);
    issue(CMD_STEP, 10'd2, 10'd0, '1);
    issue(CMD_CREATE, 10'd2, 10'd682, '0);

    repeat (700) random_word();
    // The receiver holds off while words keep coming, so the input stalls.
    hold_req++;
    repeat (12) random_word();
    drain_results();
    steady = 1'b1;
    repeat (400) random_word();
    drain_results();
    steady = 1'b0;
    repeat (640) random_word();
    drain_results();
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
